@@ hdl/thsh_pkg.sv @@
// package for the two-axis hard-stop homing block
// holds payload structs, register indexes, reset values and magnitude helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package thsh_pkg;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_STEP_SIZE       = 3'd0,
      REG_LOWER_TORQUE    = 3'd1,
      REG_UPPER_TORQUE    = 3'd2,
      REG_COLLIDE_TORQUE  = 3'd3,
      REG_TRAVEL_RANGE    = 3'd4,
      REG_RETURN_TOL      = 3'd5,
      REG_ORIGIN_CLEAR    = 3'd6,
      REG_STIFFNESS       = 3'd7
   } reg_index_type;

   localparam logic [20:0] STEP_SIZE_RESET      = 21'd262;
   localparam logic [30:0] LOWER_TORQUE_RESET   = 31'd314573;
   localparam logic [30:0] UPPER_TORQUE_RESET   = 31'd629146;
   localparam logic [30:0] COLLIDE_TORQUE_RESET = 31'd314573;
   localparam logic [30:0] TRAVEL_RANGE_RESET   = 31'd838861;
   localparam logic [30:0] RETURN_TOL_RESET     = 31'd104858;
   localparam logic [30:0] ORIGIN_CLEAR_RESET   = 31'd209715;
   localparam logic [30:0] STIFFNESS_RESET      = 31'd10485760;

   typedef struct packed {
      logic               start_req;
      logic signed [31:0] torque_a;
      logic signed [31:0] torque_b;
      logic signed [31:0] position_a;
      logic signed [31:0] position_b;
   } thsh_req_type;

   typedef struct packed {
      logic signed [31:0] reference_a;
      logic signed [31:0] reference_b;
      logic        [30:0] stiffness_out;
      logic        [2:0]  phase;
      logic               active_axis;
      logic signed [31:0] origin_a;
      logic signed [31:0] origin_b;
      logic               finished;
   } thsh_rsp_type;

   // exact magnitude of a signed word, 2^31 included
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // exact |a - b| of two signed words
   function automatic logic [32:0] dist33(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      return d[32] ? (~d + 33'd1) : d;
   endfunction

endpackage

`default_nettype wire

@@ hdl/two_axis_hard_stop_homing.sv @@
// two-axis hard-stop homing sequencer: an accepted request passes the input register,
// then the sequencer update is written into the result register that drives the response
// throughput one request per cycle while the response side does not stall
// synchronous active-high reset: phase idle, axis 0, references, lower bounds
// and origins zero, configuration registers at their default values
// depends on thsh_pkg
`timescale 1ns / 1ps
`default_nettype none

module two_axis_hard_stop_homing (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire thsh_pkg::thsh_req_type               req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output thsh_pkg::thsh_rsp_type                    rsp_payload,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [thsh_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [thsh_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [thsh_pkg::CSR_DATA_BITS-1:0]        prdata,
   output logic                                      pready
);
   import thsh_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_DOWN    = 3'd1,
      PH_UP      = 3'd2,
      PH_RETURN  = 3'd3,
      PH_COLLIDE = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   // configuration registers
   logic [20:0] step_size_ff;
   logic [30:0] lower_torque_ff, upper_torque_ff, collide_torque_ff;
   logic [30:0] travel_range_ff, return_tol_ff, origin_clear_ff, stiffness_ff;

   // input stage
   logic         s1_valid_ff;
   thsh_req_type s1_req_ff;

   // sequencer state
   phase_type          phase_ff, phase_in;
   logic               axis_ff, axis_in;
   logic               entry_ff, entry_in;
   logic signed [31:0] run_ff [2];
   logic signed [31:0] run_in [2];
   logic signed [31:0] cmd_ff [2];
   logic signed [31:0] cmd_in [2];
   logic signed [31:0] lower_ff [2];
   logic signed [31:0] lower_in [2];
   logic signed [31:0] origin_ff [2];
   logic signed [31:0] origin_in [2];
   logic               fin;

   logic         rsp_valid_ff;
   thsh_rsp_type rsp_ff, rsp_in;

   logic out_free, fire, csr_write;
   reg_index_type csr_index;

   logic signed [31:0] tq [2];
   logic signed [31:0] ps [2];
   logic signed [31:0] step_ext;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      case (csr_index)
         REG_STEP_SIZE:      prdata = {11'd0, step_size_ff};
         REG_LOWER_TORQUE:   prdata = {1'b0, lower_torque_ff};
         REG_UPPER_TORQUE:   prdata = {1'b0, upper_torque_ff};
         REG_COLLIDE_TORQUE: prdata = {1'b0, collide_torque_ff};
         REG_TRAVEL_RANGE:   prdata = {1'b0, travel_range_ff};
         REG_RETURN_TOL:     prdata = {1'b0, return_tol_ff};
         REG_ORIGIN_CLEAR:   prdata = {1'b0, origin_clear_ff};
         REG_STIFFNESS:      prdata = {1'b0, stiffness_ff};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff      <= STEP_SIZE_RESET;
         lower_torque_ff   <= LOWER_TORQUE_RESET;
         upper_torque_ff   <= UPPER_TORQUE_RESET;
         collide_torque_ff <= COLLIDE_TORQUE_RESET;
         travel_range_ff   <= TRAVEL_RANGE_RESET;
         return_tol_ff     <= RETURN_TOL_RESET;
         origin_clear_ff   <= ORIGIN_CLEAR_RESET;
         stiffness_ff      <= STIFFNESS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_STEP_SIZE:      step_size_ff      <= pwdata[20:0];
            REG_LOWER_TORQUE:   lower_torque_ff   <= pwdata[30:0];
            REG_UPPER_TORQUE:   upper_torque_ff   <= pwdata[30:0];
            REG_COLLIDE_TORQUE: collide_torque_ff <= pwdata[30:0];
            REG_TRAVEL_RANGE:   travel_range_ff   <= pwdata[30:0];
            REG_RETURN_TOL:     return_tol_ff     <= pwdata[30:0];
            REG_ORIGIN_CLEAR:   origin_clear_ff   <= pwdata[30:0];
            REG_STIFFNESS:      stiffness_ff      <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   assign tq[0]    = s1_req_ff.torque_a;
   assign tq[1]    = s1_req_ff.torque_b;
   assign ps[0]    = s1_req_ff.position_a;
   assign ps[1]    = s1_req_ff.position_b;
   assign step_ext = {11'd0, step_size_ff};

   always_comb begin
      phase_in  = phase_ff;
      axis_in   = axis_ff;
      entry_in  = entry_ff;
      run_in    = run_ff;
      cmd_in    = cmd_ff;
      lower_in  = lower_ff;
      origin_in = origin_ff;
      fin       = 1'b0;

      // start is honored only from idle or finished
      if (s1_req_ff.start_req && (phase_ff == PH_IDLE || phase_ff == PH_DONE)) begin
         phase_in = PH_DOWN;
         axis_in  = 1'b0;
         entry_in = 1'b1;
      end

      case (phase_in)
         PH_DOWN: begin
            if (entry_in) begin
               run_in[axis_in] = ps[axis_in];
               entry_in        = 1'b0;
            end
            if (mag32(tq[axis_in]) > {1'b0, lower_torque_ff}) begin
               lower_in[axis_in] = ps[axis_in];
               entry_in          = 1'b1;
               if (!axis_in) begin
                  axis_in = 1'b1;
               end else begin
                  phase_in = PH_UP;
                  axis_in  = 1'b0;
               end
            end else begin
               run_in[axis_in] = run_in[axis_in] - step_ext;
               cmd_in[axis_in] = run_in[axis_in];
            end
         end
         PH_UP: begin
            if (entry_in) begin
               run_in[axis_in] = ps[axis_in];
               entry_in        = 1'b0;
            end
            if (mag32(tq[axis_in]) > {1'b0, upper_torque_ff} ||
                dist33(ps[axis_in], lower_ff[axis_in]) > {2'b0, travel_range_ff}) begin
               phase_in = PH_RETURN;
            end else begin
               run_in[axis_in] = run_in[axis_in] + step_ext;
               cmd_in[axis_in] = run_in[axis_in];
            end
         end
         PH_RETURN: begin
            cmd_in[axis_in] = lower_ff[axis_in];
            if (dist33(ps[axis_in], lower_ff[axis_in]) < {2'b0, return_tol_ff}) begin
               entry_in = 1'b1;
               if (!axis_in) begin
                  phase_in = PH_UP;
                  axis_in  = 1'b1;
               end else begin
                  phase_in = PH_COLLIDE;
                  axis_in  = 1'b0;
               end
            end
         end
         PH_COLLIDE: begin
            if (entry_in) begin
               run_in[0] = ps[0];
               run_in[1] = ps[1];
               entry_in  = 1'b0;
            end
            // each axis is tested on its own, a free axis keeps stepping
            for (int i = 0; i < 2; i++) begin
               if (mag32(tq[i]) > {1'b0, collide_torque_ff} &&
                   dist33(ps[i], lower_ff[i]) > {2'b0, origin_clear_ff}) begin
                  fin = 1'b1;
               end else begin
                  run_in[i] = run_in[i] + step_ext;
                  cmd_in[i] = run_in[i];
               end
            end
            if (fin) begin
               origin_in[0] = ps[0];
               origin_in[1] = ps[1];
               phase_in     = PH_DONE;
               entry_in     = 1'b1;
               axis_in      = 1'b0;
            end
         end
         PH_DONE: begin
         end
         PH_IDLE: begin
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_in.reference_a   = cmd_in[0];
      rsp_in.reference_b   = cmd_in[1];
      rsp_in.stiffness_out = (phase_in == PH_DOWN || phase_in == PH_UP ||
                              phase_in == PH_RETURN || phase_in == PH_COLLIDE)
                             ? stiffness_ff : 31'd0;
      rsp_in.phase         = phase_in;
      rsp_in.active_axis   = (phase_in == PH_DOWN || phase_in == PH_UP ||
                              phase_in == PH_RETURN) ? axis_in : 1'b0;
      rsp_in.origin_a      = origin_in[0];
      rsp_in.origin_b      = origin_in[1];
      rsp_in.finished      = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         axis_ff      <= 1'b0;
         entry_ff     <= 1'b1;
         for (int i = 0; i < 2; i++) begin
            run_ff[i]    <= '0;
            cmd_ff[i]    <= '0;
            lower_ff[i]  <= '0;
            origin_ff[i] <= '0;
         end
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            axis_ff      <= axis_in;
            entry_ff     <= entry_in;
            run_ff       <= run_in;
            cmd_ff       <= cmd_in;
            lower_ff     <= lower_in;
            origin_ff    <= origin_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_req_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
